>>> rtl/mafb_pkg.sv
// ----------------------------------------------------------------------------
// Modbus ASCII frame builder package
// Shared types, character constants and the hex digit encoder.
// ----------------------------------------------------------------------------
package mafb_pkg;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned IDX_W      = 5;

  // Character positions within a frame (a short frame skips the position part).
  localparam logic [IDX_W-1:0] IDX_COLON   = 5'd0;
  localparam logic [IDX_W-1:0] IDX_WORD_LO = 5'd12;
  localparam logic [IDX_W-1:0] IDX_LRC_HI  = 5'd23;
  localparam logic [IDX_W-1:0] IDX_LF      = 5'd26;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic REQ_SHORT    = 1'b0;
  localparam logic REQ_POSITION = 1'b1;

  typedef struct packed {
    logic             load;  // capture the request and its LRC
    logic             emit;  // load the character at idx into the output register
    logic [IDX_W-1:0] idx;
  } mafb_cmd_t;

  typedef struct packed {
    logic req_type;
  } mafb_status_t;

  // Uppercase ASCII hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = CHAR_ZERO + ext;
    end else begin
      hex_char = 8'h37 + ext;
    end
  endfunction

endpackage

>>> rtl/mafb_dp.sv
// ----------------------------------------------------------------------------
// Modbus ASCII frame builder datapath
// Holds the request and its LRC, and selects one frame character per step.
// ----------------------------------------------------------------------------
module mafb_dp (
  input  logic                            clk,
  input  logic [mafb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  mafb_pkg::mafb_cmd_t             cmd,
  output mafb_pkg::mafb_status_t          status,
  output logic [mafb_pkg::OUT_DATA_W-1:0] char_out,
  output logic                            last_out
);
  import mafb_pkg::*;

  logic        req_type_r;
  logic [7:0]  slave_r;
  logic [7:0]  func_r;
  logic [15:0] addr_r;
  logic [15:0] word_r;
  logic [7:0]  count_r;
  logic [15:0] pos_r;
  logic [7:0]  lrc_r;
  logic [7:0]  char_r;
  logic        last_r;

  logic [7:0]  sum;
  logic [7:0]  pos_part;
  logic [3:0]  nib;
  logic        is_hex;
  logic [7:0]  fixed_char;
  logic [7:0]  char_nxt;

  // Byte sum modulo 256; the byte-count and position bytes count only in position frames.
  always_comb begin
    pos_part = in_tdata[55:48] + in_tdata[63:56] + in_tdata[71:64];
    sum = in_tdata[7:0] + in_tdata[15:8] + in_tdata[23:16] + in_tdata[31:24]
        + in_tdata[39:32] + in_tdata[47:40];
    if (in_tuser == REQ_POSITION) begin
      sum = sum + pos_part;
    end
  end

  always_comb begin
    nib        = 4'h0;
    is_hex     = 1'b1;
    fixed_char = CHAR_COLON;
    unique case (cmd.idx) inside
      5'd0:  begin is_hex = 1'b0; fixed_char = CHAR_COLON; end
      5'd1:  nib = slave_r[7:4];
      5'd2:  nib = slave_r[3:0];
      5'd3:  nib = func_r[7:4];
      5'd4:  nib = func_r[3:0];
      5'd5:  nib = addr_r[15:12];
      5'd6:  nib = addr_r[11:8];
      5'd7:  nib = addr_r[7:4];
      5'd8:  nib = addr_r[3:0];
      5'd9:  nib = word_r[15:12];
      5'd10: nib = word_r[11:8];
      5'd11: nib = word_r[7:4];
      5'd12: nib = word_r[3:0];
      5'd13: nib = count_r[7:4];
      5'd14: nib = count_r[3:0];
      [5'd15:5'd18]: nib = 4'h0;
      5'd19: nib = pos_r[15:12];
      5'd20: nib = pos_r[11:8];
      5'd21: nib = pos_r[7:4];
      5'd22: nib = pos_r[3:0];
      5'd23: nib = lrc_r[7:4];
      5'd24: nib = lrc_r[3:0];
      5'd25: begin is_hex = 1'b0; fixed_char = CHAR_CR; end
      5'd26: begin is_hex = 1'b0; fixed_char = CHAR_LF; end
      default: begin is_hex = 1'b0; fixed_char = CHAR_LF; end
    endcase
    char_nxt = is_hex ? hex_char(nib) : fixed_char;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_tuser;
      slave_r    <= in_tdata[7:0];
      func_r     <= in_tdata[15:8];
      addr_r     <= in_tdata[31:16];
      word_r     <= in_tdata[47:32];
      count_r    <= in_tdata[55:48];
      pos_r      <= in_tdata[71:56];
      lrc_r      <= 8'h00 - sum;
    end
    if (cmd.emit) begin
      char_r <= char_nxt;
      last_r <= (cmd.idx == IDX_LF);
    end
  end

  assign status.req_type = req_type_r;
  assign char_out        = char_r;
  assign last_out        = last_r;

endmodule

>>> rtl/mafb_ctrl.sv
// ----------------------------------------------------------------------------
// Modbus ASCII frame builder controller
// Sequences the characters of one frame and runs the output handshake.
// ----------------------------------------------------------------------------
module mafb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  mafb_pkg::mafb_status_t status,
  output mafb_pkg::mafb_cmd_t    cmd
);
  import mafb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             emit;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  // A character may move into the output register once it is empty or being taken.
  assign emit      = (state_r == ST_SEND) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SEND;
          idx_nxt   = IDX_COLON;
        end
      end
      ST_SEND: begin
        if (emit) begin
          if (idx_r == IDX_LF) begin
            state_nxt = ST_IDLE;
          end else if (idx_r == IDX_WORD_LO && status.req_type == REQ_SHORT) begin
            idx_nxt = IDX_LRC_HI;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= IDX_COLON;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.load   = accept;
  assign cmd.emit   = emit;
  assign cmd.idx    = idx_r;
  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/modbus_ascii_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// Modbus ASCII frame builder
// Turns one request into a Modbus ASCII frame, one character per output item.
// ----------------------------------------------------------------------------
// One request enters on the in_ stream; the frame leaves on the out_ stream as
// one ASCII character per item, with out_tlast high on the closing LF.
// A short command frame (in_tuser low) has 17 characters and a position-write
// frame (in_tuser high) has 27. The LRC is worked out as the request is taken.
// After a request is accepted the controller enters its send state and the
// first character is then loaded into the output register; the rest follow
// one per cycle while out_tready stays high. The character counter in the
// controller sets the pace. The next request is taken as soon as the final
// LF has entered the output register, even while that LF still waits to be
// taken. If the receiver stalls, the current character is held and the
// counter stops. Reset empties the output register and returns the controller
// to idle; any frame under way is abandoned.
// ----------------------------------------------------------------------------
module modbus_ascii_frame_builder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // slave_addr[7:0], func_code[15:8], reg_addr[31:16], reg_word[47:32],
  // byte_count[55:48], position[71:56]
  input  logic [mafb_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // ascii_char[7:0]
  output logic [mafb_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import mafb_pkg::*;

  mafb_cmd_t    cmd;
  mafb_status_t status;

  mafb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mafb_dp u_dp (
    .clk      (clk),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd      (cmd),
    .status   (status),
    .char_out (out_tdata),
    .last_out (out_tlast)
  );

endmodule
